// File: sv/ppm_pkg.sv
`timescale 1ns / 1ps

package ppm_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int LIMIT_BITS  = 7;
   localparam int CONFIRM_BITS = 16;
   localparam int TIME_BITS   = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int PERCENT_SCALE = 100;

   localparam logic [SAMPLE_BITS-1:0]  RIGHT_MIN_RESET  = SAMPLE_BITS'(1620);
   localparam logic [SAMPLE_BITS-1:0]  RIGHT_MAX_RESET  = SAMPLE_BITS'(3190);
   localparam logic [SAMPLE_BITS-1:0]  LEFT_MIN_RESET   = SAMPLE_BITS'(1280);
   localparam logic [SAMPLE_BITS-1:0]  LEFT_MAX_RESET   = SAMPLE_BITS'(2850);
   localparam logic [LIMIT_BITS-1:0]   DIFF_LIMIT_RESET = LIMIT_BITS'(10);
   localparam logic [CONFIRM_BITS-1:0] CONFIRM_MS_RESET = CONFIRM_BITS'(100);

   typedef enum logic [2:0] {
      REG_RIGHT_MIN  = 3'd0,
      REG_RIGHT_MAX  = 3'd1,
      REG_LEFT_MIN   = 3'd2,
      REG_LEFT_MAX   = 3'd3,
      REG_DIFF_LIMIT = 3'd4,
      REG_CONFIRM_MS = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_FAULT   = 2'd0,
      MODE_CONFIRM = 2'd1,
      MODE_OK      = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SPAN_R,
      SEQ_SPAN_L,
      SEQ_PCT_R,
      SEQ_PCT_L,
      SEQ_FINISH
   } seq_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] right_pot;
      logic [SAMPLE_BITS-1:0] left_pot;
      logic [TIME_BITS-1:0]   now_ms;
   } req_data_type;

   typedef struct packed {
      logic       pedals_ok;
      logic       throttle_cleared;
      logic [1:0] monitor_state;
   } rsp_data_type;

endpackage

// File: sv/pedal_plausibility_monitor.sv
`timescale 1ns / 1ps

// Accelerator pedal plausibility monitor. Each request carries both pot samples and the
// current millisecond time; the block turns each sample into a percent of its configured
// span, compares the two and steps a fault / confirming / ok monitor, giving one response
// per request. All four divisions (two spans by 100, two offsets by their span) run on one
// shared restoring divider that yields one quotient bit per cycle, so a request occupies
// the block through the four divisions and the finish step, plus any response stall;
// req_stall is high for that time, while a finished response may still wait on rsp_stall.
// Registers sit at byte addresses 0x00 right_min, 0x04 right_max, 0x08 left_min, 0x0C
// left_max, 0x10 diff_limit, 0x14 confirm_ms; configure only while idle.
module pedal_plausibility_monitor
   import ppm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_data_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_data_type             rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int SB = SAMPLE_BITS;
   localparam int CNT_BITS = $clog2(SB);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SB - 1);

   logic [SB-1:0]           right_min_ff, right_max_ff, left_min_ff, left_max_ff;
   logic [LIMIT_BITS-1:0]   diff_limit_ff;
   logic [CONFIRM_BITS-1:0] confirm_ms_ff;
   reg_index_type           csr_index;
   logic                    csr_write;

   seq_type seq_ff, seq_in;
   logic    accept, div_busy, div_last, div_load, finish_go;

   logic [SB-1:0]        rp_ff, lp_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic signed [SB:0]   span_r_ff, span_l_ff, pct_r_ff, pct_l_ff;

   logic [SB-1:0]       dvd_ff, dvd_in, rem_ff, rem_in, dvs_ff;
   logic                neg_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [SB:0]         rem_sh, rem_sub;
   logic                q_bit;
   logic signed [SB:0]  q_mag, q_signed, span_val;

   logic signed [SB:0] op_num, op_den;
   logic [SB-1:0]      num_mag, den_mag;

   mode_type             mode_ff, mode_upd;
   logic [TIME_BITS-1:0] start_ff, start_upd, elapsed;
   logic                 ok_flag_ff, ok_flag_upd;
   logic signed [SB+1:0] pct_diff;
   logic [SB:0]          diff_abs;
   logic                 in_range, too_far, timed_out;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_upd;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         right_min_ff  <= RIGHT_MIN_RESET;
         right_max_ff  <= RIGHT_MAX_RESET;
         left_min_ff   <= LEFT_MIN_RESET;
         left_max_ff   <= LEFT_MAX_RESET;
         diff_limit_ff <= DIFF_LIMIT_RESET;
         confirm_ms_ff <= CONFIRM_MS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_RIGHT_MIN:  right_min_ff  <= csr_pwdata[SB-1:0];
            REG_RIGHT_MAX:  right_max_ff  <= csr_pwdata[SB-1:0];
            REG_LEFT_MIN:   left_min_ff   <= csr_pwdata[SB-1:0];
            REG_LEFT_MAX:   left_max_ff   <= csr_pwdata[SB-1:0];
            REG_DIFF_LIMIT: diff_limit_ff <= csr_pwdata[LIMIT_BITS-1:0];
            REG_CONFIRM_MS: confirm_ms_ff <= csr_pwdata[CONFIRM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_RIGHT_MIN:  csr_prdata = CSR_DATA_BITS'(right_min_ff);
         REG_RIGHT_MAX:  csr_prdata = CSR_DATA_BITS'(right_max_ff);
         REG_LEFT_MIN:   csr_prdata = CSR_DATA_BITS'(left_min_ff);
         REG_LEFT_MAX:   csr_prdata = CSR_DATA_BITS'(left_max_ff);
         REG_DIFF_LIMIT: csr_prdata = CSR_DATA_BITS'(diff_limit_ff);
         REG_CONFIRM_MS: csr_prdata = CSR_DATA_BITS'(confirm_ms_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // sequencer next state
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SEQ_IDLE:   if (req_valid) seq_in = SEQ_SPAN_R;
         SEQ_SPAN_R: if (cnt_ff == CNT_LAST) seq_in = SEQ_SPAN_L;
         SEQ_SPAN_L: if (cnt_ff == CNT_LAST) seq_in = SEQ_PCT_R;
         SEQ_PCT_R:  if (cnt_ff == CNT_LAST) seq_in = SEQ_PCT_L;
         SEQ_PCT_L:  if (cnt_ff == CNT_LAST) seq_in = SEQ_FINISH;
         SEQ_FINISH: if (!rsp_valid_ff || !rsp_stall) seq_in = SEQ_IDLE;
         default:    seq_in = SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      div_busy  = 1'b0;
      finish_go = 1'b0;
      unique case (seq_ff) inside
         SEQ_IDLE:   req_stall = 1'b0;
         SEQ_SPAN_R, SEQ_SPAN_L, SEQ_PCT_R, SEQ_PCT_L: div_busy = 1'b1;
         SEQ_FINISH: finish_go = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign accept   = req_valid && !req_stall;
   assign div_last = div_busy && (cnt_ff == CNT_LAST);
   assign div_load = accept || (div_last && seq_ff != SEQ_PCT_L);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_IDLE;
      end else begin
         seq_ff <= seq_in;
      end
   end

   // operands for the next division
   always_comb begin
      case (seq_ff)
         SEQ_IDLE: begin
            op_num = $signed({1'b0, right_max_ff}) - $signed({1'b0, right_min_ff});
            op_den = (SB+1)'(PERCENT_SCALE);
         end
         SEQ_SPAN_R: begin
            op_num = $signed({1'b0, left_max_ff}) - $signed({1'b0, left_min_ff});
            op_den = (SB+1)'(PERCENT_SCALE);
         end
         SEQ_SPAN_L: begin
            op_num = $signed({1'b0, rp_ff}) - $signed({1'b0, right_min_ff});
            op_den = span_r_ff;
         end
         default: begin
            op_num = $signed({1'b0, lp_ff}) - $signed({1'b0, left_min_ff});
            op_den = span_l_ff;
         end
      endcase
      num_mag = op_num[SB] ? SB'(-op_num) : op_num[SB-1:0];
      den_mag = op_den[SB] ? SB'(-op_den) : op_den[SB-1:0];
   end

   // shared restoring divider, one quotient bit per cycle
   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[SB-1]};
      rem_sub  = rem_sh - {1'b0, dvs_ff};
      q_bit    = (rem_sh >= {1'b0, dvs_ff});
      rem_in   = q_bit ? rem_sub[SB-1:0] : rem_sh[SB-1:0];
      dvd_in   = {dvd_ff[SB-2:0], q_bit};
      q_mag    = $signed({1'b0, dvd_in});
      q_signed = neg_ff ? -q_mag : q_mag;
      span_val = (dvd_in == '0) ? (SB+1)'(1) : q_signed;
   end

   always_ff @(posedge clock) begin
      if (div_load) begin
         dvd_ff <= num_mag;
         rem_ff <= '0;
         dvs_ff <= den_mag;
         neg_ff <= op_num[SB] ^ op_den[SB];
         cnt_ff <= '0;
      end else if (div_busy) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rp_ff  <= req_data.right_pot;
         lp_ff  <= req_data.left_pot;
         now_ff <= req_data.now_ms;
      end
      if (div_last) begin
         unique case (seq_ff)
            SEQ_SPAN_R: span_r_ff <= span_val;
            SEQ_SPAN_L: span_l_ff <= span_val;
            SEQ_PCT_R:  pct_r_ff  <= q_signed;
            SEQ_PCT_L:  pct_l_ff  <= q_signed;
            default: ;
         endcase
      end
   end

   // monitor next state
   always_comb begin
      pct_diff  = $signed({pct_r_ff[SB], pct_r_ff}) - $signed({pct_l_ff[SB], pct_l_ff});
      diff_abs  = pct_diff[SB+1] ? (SB+1)'(-pct_diff) : pct_diff[SB:0];
      too_far   = diff_abs > (SB+1)'(diff_limit_ff);
      in_range  = (rp_ff > right_min_ff) && (rp_ff < right_max_ff) &&
                  (lp_ff > left_min_ff) && (lp_ff < left_max_ff);
      elapsed   = now_ff - start_ff;
      timed_out = elapsed >= TIME_BITS'(confirm_ms_ff);
      mode_upd  = mode_ff;
      start_upd = start_ff;
      unique case (mode_ff)
         MODE_CONFIRM: begin
            if (timed_out) mode_upd = MODE_FAULT;
            else if (!too_far) mode_upd = MODE_OK;
         end
         default: begin
            if (!in_range) begin
               mode_upd = MODE_FAULT;
            end else if (too_far) begin
               mode_upd  = MODE_CONFIRM;
               start_upd = now_ff;
            end else begin
               mode_upd = MODE_OK;
            end
         end
      endcase
   end

   // monitor outputs
   always_comb begin
      ok_flag_upd = ok_flag_ff;
      unique case (mode_upd)
         MODE_OK:      ok_flag_upd = 1'b1;
         MODE_CONFIRM: ok_flag_upd = ok_flag_ff;
         default:      ok_flag_upd = 1'b0;
      endcase
      rsp_data_upd.pedals_ok        = ok_flag_upd;
      rsp_data_upd.throttle_cleared = (mode_upd != MODE_OK) && (mode_upd != MODE_CONFIRM);
      rsp_data_upd.monitor_state    = mode_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_FAULT;
         start_ff   <= '0;
         ok_flag_ff <= 1'b0;
      end else if (finish_go) begin
         mode_ff    <= mode_upd;
         start_ff   <= start_upd;
         ok_flag_ff <= ok_flag_upd;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_go) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (finish_go) rsp_data_ff <= rsp_data_upd;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> seq_ff == SEQ_SPAN_R)
      else $error("accepted request did not start the span division");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(seq_ff) == SEQ_FINISH)
      else $error("response raised outside the finish step");

   a_rem_below_dvs: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> rem_ff < dvs_ff)
      else $error("divider remainder not below divisor");

   a_ok_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.monitor_state == MODE_OK |-> rsp_data_ff.pedals_ok)
      else $error("ok state without pedals_ok");
`endif

endmodule
